### design/single_server_queue_tick_core_defines.svh
// Shared assertion macros for the queue tick core.
`ifndef SINGLE_SERVER_QUEUE_TICK_CORE_DEFINES_SVH
`define SINGLE_SERVER_QUEUE_TICK_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSQT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssqt assertion failed");

// Next-cycle implication, disabled during reset.
`define SSQT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssqt assertion failed");

`endif

### design/ssqt_pkg.sv
package ssqt_pkg;

  localparam int RING_SLOTS = 8;
  localparam int IDX_W      = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W      = (IDX_W + 1 > 3) ? IDX_W + 1 : 3;

  localparam int ID_W   = 16;
  localparam int TICK_W = 32;
  localparam int SVC_W  = 4;
  localparam int QD_W   = 3;

  // Command queue between front and back.
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;

  typedef logic [IDX_W-1:0] idx_t;

  // One tick transaction as classified by the front end.
  typedef struct packed {
    logic              arrives;
    logic [SVC_W-1:0]  svc;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cq_stat_t;

  function automatic idx_t next_slot(idx_t i);
    return (i == idx_t'(RING_SLOTS - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

endpackage

### design/single_server_queue_tick_core.sv
// Single-server FIFO queue, one tick per transaction.
// An accepted tick enters the command queue; its pop registers done and the results.
// Throughput: one tick per cycle; the back end pops a tick every cycle the queue holds one.
// busy rises only if the two-entry command queue fills, which cannot happen
// since done cannot be held off. Reset (rst, synchronous, active high) clears
// ids, tick count, ring pointers, server time and wait sum; ring data is not cleared.
module single_server_queue_tick_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        arrives,
  input  logic [3:0]  service_len,
  output logic        done,
  output logic [31:0] tick_now,
  output logic [15:0] arrival_id,
  output logic        dropped,
  output logic        started,
  output logic [15:0] started_id,
  output logic [31:0] waited,
  output logic        busy_res,
  output logic [31:0] wait_total,
  output logic [2:0]  queued
);

  // Front end: numbers each tick transaction and stamps the arrival id.
  // Command queue: decouples the front from the ring/server back end.
  // Back end: enqueue, countdown or dequeue, saturating wait sum.

  ssqt_pkg::cq_stat_t cq_stat;
  ssqt_pkg::cmd_t     push_cmd;
  ssqt_pkg::cmd_t     head_cmd;
  logic               push;
  logic               pop;

  assign busy = cq_stat.full;

  ssqt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .arrives     (arrives),
    .service_len (service_len),
    .cq_stat     (cq_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  ssqt_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head_data (head_cmd),
    .stat      (cq_stat)
  );

  ssqt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cq_stat    (cq_stat),
    .cmd        (head_cmd),
    .pop        (pop),
    .done       (done),
    .tick_now   (tick_now),
    .arrival_id (arrival_id),
    .dropped    (dropped),
    .started    (started),
    .started_id (started_id),
    .waited     (waited),
    .busy_res   (busy_res),
    .wait_total (wait_total),
    .queued     (queued)
  );

endmodule

### design/ssqt_front.sv
module ssqt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 arrives,
  input  logic [3:0]           service_len,
  input  ssqt_pkg::cq_stat_t   cq_stat,
  output logic                 push,
  output ssqt_pkg::cmd_t       cmd
);

  logic [ssqt_pkg::ID_W-1:0]   next_id;
  logic [ssqt_pkg::TICK_W-1:0] tick_counter;

  assign push = start && !cq_stat.full;

  always_comb begin
    cmd.arrives = arrives;
    cmd.svc     = service_len;
    cmd.id      = next_id;
    cmd.now     = tick_counter;
  end

  // ids and tick numbers depend only on the input stream
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id      <= '0;
      tick_counter <= '0;
    end else if (push) begin
      tick_counter <= tick_counter + 1'b1;
      if (arrives) begin
        next_id <= next_id + 1'b1;
      end
    end
  end

endmodule

### design/ssqt_cmd_fifo.sv
module ssqt_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ssqt_pkg::cmd_t     push_data,
  input  logic               pop,
  output ssqt_pkg::cmd_t     head_data,
  output ssqt_pkg::cq_stat_t stat
);

  ssqt_pkg::cmd_t                   mem [ssqt_pkg::CQ_DEPTH];
  logic [ssqt_pkg::CQ_PTR_W-1:0]    wr_ptr;
  logic [ssqt_pkg::CQ_PTR_W-1:0]    rd_ptr;
  logic [ssqt_pkg::CQ_CNT_W-1:0]    count;

  assign stat.full  = (count == ssqt_pkg::CQ_CNT_W'(ssqt_pkg::CQ_DEPTH));
  assign stat.empty = (count == '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/ssqt_back.sv
`include "single_server_queue_tick_core_defines.svh"

module ssqt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ssqt_pkg::cq_stat_t            cq_stat,
  input  ssqt_pkg::cmd_t                cmd,
  output logic                          pop,
  output logic                          done,
  output logic [31:0]                   tick_now,
  output logic [15:0]                   arrival_id,
  output logic                          dropped,
  output logic                          started,
  output logic [15:0]                   started_id,
  output logic [31:0]                   waited,
  output logic                          busy_res,
  output logic [31:0]                   wait_total,
  output logic [2:0]                    queued
);

  logic [ssqt_pkg::ID_W-1:0]   ring_ids           [ssqt_pkg::RING_SLOTS];
  logic [ssqt_pkg::TICK_W-1:0] ring_arrival_ticks [ssqt_pkg::RING_SLOTS];
  logic [ssqt_pkg::SVC_W-1:0]  ring_service_lens  [ssqt_pkg::RING_SLOTS];

  ssqt_pkg::idx_t              head_index, head_index_next;
  ssqt_pkg::idx_t              tail_index, tail_index_next;
  logic [ssqt_pkg::SVC_W-1:0]  remaining_service, remaining_service_next;
  logic [ssqt_pkg::TICK_W-1:0] wait_sum, wait_sum_next;

  logic                        enq, drop_c, start_c, busy_c, bypass;
  ssqt_pkg::idx_t              hp;
  logic [ssqt_pkg::ID_W-1:0]   ent_id;
  logic [ssqt_pkg::TICK_W-1:0] ent_tick;
  logic [ssqt_pkg::SVC_W-1:0]  ent_svc;
  logic [ssqt_pkg::TICK_W-1:0] waited_c;
  logic [ssqt_pkg::TICK_W:0]   sum_c;
  logic [ssqt_pkg::CNT_W-1:0]  count_c;

  assign pop = !cq_stat.empty;

  always_comb begin
    enq     = cmd.arrives && (ssqt_pkg::next_slot(tail_index) != head_index);
    drop_c  = cmd.arrives && !enq;
    tail_index_next = enq ? ssqt_pkg::next_slot(tail_index) : tail_index;

    hp      = ssqt_pkg::next_slot(head_index);
    // head entry written in this same tick comes straight from the command
    bypass  = enq && (hp == tail_index_next);
    ent_id   = bypass ? cmd.id  : ring_ids[hp];
    ent_tick = bypass ? cmd.now : ring_arrival_ticks[hp];
    ent_svc  = bypass ? cmd.svc : ring_service_lens[hp];

    busy_c  = (remaining_service != '0);
    start_c = !busy_c && (head_index != tail_index_next);

    head_index_next        = head_index;
    remaining_service_next = remaining_service;
    wait_sum_next          = wait_sum;
    waited_c               = cmd.now - ent_tick;
    sum_c                  = {1'b0, wait_sum} + {1'b0, waited_c};

    if (busy_c) begin
      remaining_service_next = remaining_service - 1'b1;
    end else if (start_c) begin
      head_index_next        = hp;
      remaining_service_next = ent_svc;
      wait_sum_next          = sum_c[ssqt_pkg::TICK_W] ? '1 : sum_c[ssqt_pkg::TICK_W-1:0];
    end

    if (tail_index_next >= head_index_next) begin
      count_c = ssqt_pkg::CNT_W'(tail_index_next) - ssqt_pkg::CNT_W'(head_index_next);
    end else begin
      count_c = ssqt_pkg::CNT_W'(tail_index_next) + ssqt_pkg::CNT_W'(ssqt_pkg::RING_SLOTS)
              - ssqt_pkg::CNT_W'(head_index_next);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && enq) begin
      ring_ids[tail_index_next]           <= cmd.id;
      ring_arrival_ticks[tail_index_next] <= cmd.now;
      ring_service_lens[tail_index_next]  <= cmd.svc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index        <= '0;
      tail_index        <= '0;
      remaining_service <= '0;
      wait_sum          <= '0;
      done              <= 1'b0;
    end else begin
      done <= pop;
      if (pop) begin
        head_index        <= head_index_next;
        tail_index        <= tail_index_next;
        remaining_service <= remaining_service_next;
        wait_sum          <= wait_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tick_now   <= cmd.now;
      arrival_id <= cmd.arrives ? cmd.id : '0;
      dropped    <= drop_c;
      started    <= start_c;
      started_id <= start_c ? ent_id : '0;
      waited     <= start_c ? waited_c : '0;
      busy_res   <= busy_c;
      wait_total <= wait_sum_next;
      queued     <= count_c[ssqt_pkg::QD_W-1:0];
    end
  end

  `SSQT_ASSERT_IMPL(a_start_xor_busy, clk, rst, done, !(started && busy_res))
  `SSQT_ASSERT_NEXT(a_busy_counts, clk, rst, pop && remaining_service != '0,
                    done && busy_res && !started)
  `SSQT_ASSERT_NEXT(a_drop_when_full, clk, rst, pop && drop_c,
                    done && dropped && (started || queued == 3'(ssqt_pkg::RING_SLOTS - 1)))
  `SSQT_ASSERT_NEXT(a_sum_monotonic, clk, rst, pop, wait_sum >= $past(wait_sum))

endmodule
